FILE: src/sdg_pkg.sv
// Shared types and operation codes for the small directed graph store.
package sdg_pkg;

  localparam int KEY_W   = 8;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 4;

  localparam logic [KIND_W-1:0] OP_CLEAR       = 3'd0;
  localparam logic [KIND_W-1:0] OP_ADD_NODE    = 3'd1;
  localparam logic [KIND_W-1:0] OP_ADD_ARC     = 3'd2;
  localparam logic [KIND_W-1:0] OP_SEARCH_NODE = 3'd3;
  localparam logic [KIND_W-1:0] OP_SEARCH_ARC  = 3'd4;
  localparam logic [KIND_W-1:0] OP_COUNT       = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 4'hF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key_from;
    logic [KEY_W-1:0]  key_to;
  } sdg_in_t;

  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] node_count;
  } sdg_out_t;

  // Flags and running count handed from cell to cell along the chain.
  typedef struct packed {
    logic               from_hit;
    logic               to_hit;
    logic               free1_hit;
    logic               free2_hit;
    logic [COUNT_W-1:0] count;
  } sdg_flags_t;

  // Write strobes broadcast from the controller to every cell.
  typedef struct packed {
    logic clear;
    logic create_a;
    logic create_b;
    logic set_arc;
  } sdg_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } sdg_state_t;

endpackage

FILE: src/sdg_cell.sv
// One node slot of the graph store: key, used bit, arc row and chain stage.
module sdg_cell #(
  parameter int NODES = 8,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sdg_pkg::KEY_W-1:0]     key_from,
  input  logic [sdg_pkg::KEY_W-1:0]     key_to,
  input  logic [NODES-1:0]              in_vec_all,
  input  sdg_pkg::sdg_wr_t              wr,
  input  logic [$clog2(NODES)-1:0]      wr_a_idx,
  input  logic [$clog2(NODES)-1:0]      wr_b_idx,
  input  logic [$clog2(NODES)-1:0]      wr_set_idx,
  input  logic [$clog2(NODES)-1:0]      wr_col_idx,
  input  sdg_pkg::sdg_flags_t           prev_flags,
  input  logic [$clog2(NODES)-1:0]      prev_from_idx,
  input  logic [$clog2(NODES)-1:0]      prev_to_idx,
  input  logic [$clog2(NODES)-1:0]      prev_free1_idx,
  input  logic [$clog2(NODES)-1:0]      prev_free2_idx,
  input  logic [NODES-1:0]              prev_from_row,
  input  logic [NODES-1:0]              prev_in_vec,
  output sdg_pkg::sdg_flags_t           next_flags,
  output logic [$clog2(NODES)-1:0]      next_from_idx,
  output logic [$clog2(NODES)-1:0]      next_to_idx,
  output logic [$clog2(NODES)-1:0]      next_free1_idx,
  output logic [$clog2(NODES)-1:0]      next_free2_idx,
  output logic [NODES-1:0]              next_from_row,
  output logic [NODES-1:0]              next_in_vec
);

  localparam int IW = $clog2(NODES);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [sdg_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      used_r, used_nxt;
  logic [NODES-1:0]          row_r, row_nxt;

  sdg_pkg::sdg_flags_t       flags_r, flags_nxt;
  logic [IW-1:0]             from_idx_r, from_idx_nxt;
  logic [IW-1:0]             to_idx_r, to_idx_nxt;
  logic [IW-1:0]             free1_idx_r, free1_idx_nxt;
  logic [IW-1:0]             free2_idx_r, free2_idx_nxt;
  logic [NODES-1:0]          from_row_r, from_row_nxt;
  logic [NODES-1:0]          in_vec_r, in_vec_nxt;

  logic hit_from, hit_to, is_free, cand;
  logic here_a, here_b, here_set;

  // Chain stage: merge own slot into the request flowing past.
  always_comb begin
    hit_from = used_r && (key_r == key_from);
    hit_to   = used_r && (key_r == key_to);
    is_free  = !used_r;
    cand     = used_r && (|(row_r & (row_r - NODES'(1)))) && !in_vec_all[IDX];

    flags_nxt.from_hit  = prev_flags.from_hit | hit_from;
    flags_nxt.to_hit    = prev_flags.to_hit | hit_to;
    flags_nxt.free1_hit = prev_flags.free1_hit | is_free;
    flags_nxt.free2_hit = prev_flags.free2_hit | (prev_flags.free1_hit & is_free);
    flags_nxt.count     = (cand && prev_flags.count != sdg_pkg::COUNT_SAT) ?
                          prev_flags.count + 4'd1 : prev_flags.count;

    from_idx_nxt  = prev_flags.from_hit ? prev_from_idx : MY_IDX;
    from_row_nxt  = prev_flags.from_hit ? prev_from_row : row_r;
    to_idx_nxt    = prev_flags.to_hit ? prev_to_idx : MY_IDX;
    free1_idx_nxt = prev_flags.free1_hit ? prev_free1_idx : MY_IDX;
    free2_idx_nxt = prev_flags.free2_hit ? prev_free2_idx : MY_IDX;
    in_vec_nxt    = prev_in_vec | (used_r ? row_r : '0);
  end

  // Slot update from the broadcast write strobes.
  always_comb begin
    here_a   = wr.create_a && (wr_a_idx == MY_IDX);
    here_b   = wr.create_b && (wr_b_idx == MY_IDX);
    here_set = wr.set_arc && (wr_set_idx == MY_IDX);
    key_nxt  = key_r;
    used_nxt = used_r;
    row_nxt  = row_r;
    if (wr.clear) begin
      used_nxt = 1'b0;
      row_nxt  = '0;
    end else begin
      if (here_a) begin
        key_nxt  = key_from;
        used_nxt = 1'b1;
        row_nxt  = '0;
      end else if (here_b) begin
        key_nxt  = key_to;
        used_nxt = 1'b1;
        row_nxt  = '0;
      end
      if (here_set) begin
        row_nxt = row_nxt | (NODES'(1) << wr_col_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      row_r   <= '0;
      flags_r <= '0;
    end else begin
      used_r  <= used_nxt;
      row_r   <= row_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    from_idx_r  <= from_idx_nxt;
    to_idx_r    <= to_idx_nxt;
    free1_idx_r <= free1_idx_nxt;
    free2_idx_r <= free2_idx_nxt;
    from_row_r  <= from_row_nxt;
    in_vec_r    <= in_vec_nxt;
  end

  assign next_flags     = flags_r;
  assign next_from_idx  = from_idx_r;
  assign next_to_idx    = to_idx_r;
  assign next_free1_idx = free1_idx_r;
  assign next_free2_idx = free2_idx_r;
  assign next_from_row  = from_row_r;
  assign next_in_vec    = in_vec_r;

endmodule

FILE: src/small_digraph_store_core.sv
// Top level of the small directed graph store: controller and chain of slot cells.
//
// Usage: drive a request (kind, key_from, key_to) on in_req and raise start
// while busy is low; the request is taken at that clock edge. Exactly one
// result follows on out_res, shown for a single cycle with out_valid high.
// The receiver cannot hold results off, so take them when out_valid is high.
//
// Each slot of the graph lives in one cell of a chain. A request travels
// the chain one cell per cycle, collecting key matches, the first two free
// slots, the source row, the column OR of all arcs and the running count.
// Count needs two trips down the chain (one for the incoming-arc vector,
// one to tally the qualifying nodes); each trip walks the whole chain.
// Busy drops in the strobe cycle, so a new request can be taken there;
// busy stays high until then, so requests never overlap in the chain.
//
// Reset (rst_n low, synchronous) empties the graph and returns to idle.
// Clear does the same through a normal request and returns success = 0.
module small_digraph_store_core #(
  parameter int NODES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sdg_pkg::sdg_in_t  in_req,
  output logic              out_valid,
  output sdg_pkg::sdg_out_t out_res
);

  localparam int IW = $clog2(NODES);

  sdg_pkg::sdg_state_t state_r, state_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic                pass2_r, pass2_nxt;
  sdg_pkg::sdg_in_t    req_r, req_nxt;
  logic [NODES-1:0]    in_vec_r, in_vec_nxt;
  logic                out_valid_r, out_valid_nxt;
  sdg_pkg::sdg_out_t   out_res_r, out_res_nxt;

  // Chain links: link 0 feeds the first cell, link NODES leaves the last.
  sdg_pkg::sdg_flags_t flags_l     [NODES+1];
  logic [IW-1:0]       from_idx_l  [NODES+1];
  logic [IW-1:0]       to_idx_l    [NODES+1];
  logic [IW-1:0]       free1_idx_l [NODES+1];
  logic [IW-1:0]       free2_idx_l [NODES+1];
  logic [NODES-1:0]    from_row_l  [NODES+1];
  logic [NODES-1:0]    in_vec_l    [NODES+1];

  sdg_pkg::sdg_wr_t wr;
  logic [IW-1:0]    wr_a_idx, wr_b_idx, wr_set_idx, wr_col_idx;

  // Add-arc planning from the end of the chain.
  sdg_pkg::sdg_flags_t fin;
  logic                same_key, arc_bit, present;
  logic                a_ok, a_new, b_ok, b_new;
  logic [IW-1:0]       a_idx, b_idx;

  // Inject an empty request state at the head of the chain.
  assign flags_l[0]     = '0;
  assign from_idx_l[0]  = '0;
  assign to_idx_l[0]    = '0;
  assign free1_idx_l[0] = '0;
  assign free2_idx_l[0] = '0;
  assign from_row_l[0]  = '0;
  assign in_vec_l[0]    = '0;

  for (genvar g = 0; g < NODES; g++) begin : g_cell
    sdg_cell #(
      .NODES (NODES),
      .IDX   (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .key_from       (req_r.key_from),
      .key_to         (req_r.key_to),
      .in_vec_all     (in_vec_r),
      .wr             (wr),
      .wr_a_idx       (wr_a_idx),
      .wr_b_idx       (wr_b_idx),
      .wr_set_idx     (wr_set_idx),
      .wr_col_idx     (wr_col_idx),
      .prev_flags     (flags_l[g]),
      .prev_from_idx  (from_idx_l[g]),
      .prev_to_idx    (to_idx_l[g]),
      .prev_free1_idx (free1_idx_l[g]),
      .prev_free2_idx (free2_idx_l[g]),
      .prev_from_row  (from_row_l[g]),
      .prev_in_vec    (in_vec_l[g]),
      .next_flags     (flags_l[g+1]),
      .next_from_idx  (from_idx_l[g+1]),
      .next_to_idx    (to_idx_l[g+1]),
      .next_free1_idx (free1_idx_l[g+1]),
      .next_free2_idx (free2_idx_l[g+1]),
      .next_from_row  (from_row_l[g+1]),
      .next_in_vec    (in_vec_l[g+1])
    );
  end

  // Plan an arc insert: pick source and destination slots, new or existing.
  always_comb begin
    fin      = flags_l[NODES];
    same_key = req_r.key_from == req_r.key_to;
    arc_bit  = from_row_l[NODES][to_idx_l[NODES]];
    present  = fin.from_hit && fin.to_hit && (same_key || arc_bit);

    a_ok  = 1'b0;
    a_new = 1'b0;
    a_idx = from_idx_l[NODES];
    if (fin.from_hit) begin
      a_ok = 1'b1;
    end else if (fin.free1_hit) begin
      a_ok  = 1'b1;
      a_new = 1'b1;
      a_idx = free1_idx_l[NODES];
    end

    // A self loop reuses the source slot; an existing destination keeps its slot; otherwise take the next free one.
    if (same_key) begin
      b_ok  = a_ok;
      b_new = 1'b0;
      b_idx = a_idx;
    end else if (fin.to_hit) begin
      b_ok  = 1'b1;
      b_new = 1'b0;
      b_idx = to_idx_l[NODES];
    end else if (a_new) begin
      b_ok  = fin.free2_hit;
      b_new = 1'b1;
      b_idx = free2_idx_l[NODES];
    end else begin
      b_ok  = fin.free1_hit;
      b_new = 1'b1;
      b_idx = free1_idx_l[NODES];
    end
  end

  // Controller: accept, walk the chain (twice for count), then commit writes and the result.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass2_nxt     = pass2_r;
    req_nxt       = req_r;
    in_vec_nxt    = in_vec_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    wr            = '0;
    wr_a_idx      = a_idx;
    wr_b_idx      = b_idx;
    wr_set_idx    = a_idx;
    wr_col_idx    = b_idx;

    unique case (state_r)
      sdg_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          cnt_nxt   = '0;
          pass2_nxt = 1'b0;
          state_nxt = sdg_pkg::ST_SCAN;
        end
      end
      sdg_pkg::ST_SCAN: begin
        // Advance until the request has left the last cell.
        if (cnt_r == IW'(NODES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = sdg_pkg::ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      sdg_pkg::ST_FINISH: begin
        state_nxt     = sdg_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        case (req_r.kind)
          sdg_pkg::OP_CLEAR: begin
            wr.clear = 1'b1;
          end
          sdg_pkg::OP_ADD_NODE: begin
            if (!fin.from_hit && fin.free1_hit) begin
              wr.create_a         = 1'b1;
              wr_a_idx            = free1_idx_l[NODES];
              out_res_nxt.success = 1'b1;
            end
          end
          sdg_pkg::OP_ADD_ARC: begin
            // A new source stays even if the destination finds no slot.
            if (!present) begin
              wr.create_a = a_new;
              wr.create_b = a_ok && b_ok && b_new;
              if (a_ok && b_ok) begin
                wr.set_arc          = 1'b1;
                out_res_nxt.success = 1'b1;
              end
            end
          end
          sdg_pkg::OP_SEARCH_NODE: begin
            out_res_nxt.success = fin.from_hit;
          end
          sdg_pkg::OP_SEARCH_ARC: begin
            out_res_nxt.success = present;
          end
          sdg_pkg::OP_COUNT: begin
            if (!pass2_r) begin
              // Hold the incoming-arc vector and send the request round again.
              in_vec_nxt    = in_vec_l[NODES];
              pass2_nxt     = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = sdg_pkg::ST_SCAN;
            end else begin
              out_res_nxt.node_count = fin.count;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = sdg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdg_pkg::ST_IDLE;
      cnt_r       <= '0;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass2_r     <= pass2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    in_vec_r  <= in_vec_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = state_r != sdg_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
